// File: hw/rtl/cla_pkg.sv
// Shared constants for the console line assembler: field widths, reset values
// and the control character codes.
// No dependencies.
package cla_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 6;

  localparam int unsigned BufferDepthDefault = 64;
  localparam logic [LenW-1:0] MaxLenReset = LenW'(63);

  // Control character codes
  localparam logic [ByteW-1:0] ChBs    = 8'd8;
  localparam logic [ByteW-1:0] ChDel   = 8'd127;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChNone  = 8'd255;

endpackage

// File: hw/rtl/cla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/console_line_assembler.sv
// Console line assembler: takes one typed byte per transfer; a commit emits the
// stored line one character per cycle unless the output stalls, the first one
// passing through the RAM read data register and then the output register. No
// byte is taken while the line's entries are still being read from the RAM
// (input also waits out every output stall once both read stages are full), bounded
// by the single read port of the line RAM. Reset clears the fill count and sets the
// maximum length to 63; the line RAM is not cleared and needs no pass.
// Depends on cla_pkg and cla_ram.
module console_line_assembler
  import cla_pkg::*;
#(
  parameter int unsigned BufferDepth = BufferDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: max_line_length
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LenW-1:0]  cfg_data_i,
  // typed bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
  // committed line characters
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [13:8] line_length, [15:14] zero
  output logic             m_axis_tlast    // last_of_line
);

  localparam int unsigned FillW = $clog2(BufferDepth);
  // largest effective line length: one entry short of the buffer
  localparam logic [LenW-1:0] LimTop = LenW'(BufferDepth - 1);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]   max_q, max_d;
  logic [LenW-1:0]   len_q, len_d;        // length of the line being read out
  logic [LenW-1:0]   rd_idx_q, rd_idx_d;  // next entry to read
  // stage A: RAM read data register
  logic              a_vld_q, a_vld_d;
  logic              a_last_q, a_last_d;
  logic [LenW-1:0]   a_len_q, a_len_d;
  // stage B: output register
  logic              b_vld_q, b_vld_d;
  logic              b_last_q, b_last_d;
  logic [LenW-1:0]   b_len_q, b_len_d;
  logic [ByteW-1:0]  b_byte_q, b_byte_d;

  logic [ByteW-1:0]  ram_rdata;
  logic              ram_we;
  logic              ram_re;

  logic              in_xfer;
  logic [LenW-1:0]   lim;
  logic [LenW-1:0]   fill_ext;
  logic [LenW-1:0]   nfill;
  logic [LenW-1:0]   delim_commit;
  logic [LenW-1:0]   commit;
  logic              is_printable;
  logic              b_load;
  logic              a_move;
  logic [LenW-1:0]   rd_idx_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Clamp the register to 1 .. BufferDepth-1
  always_comb begin
    priority if (max_q == '0) begin
      lim = LenW'(1);
    end else if (max_q > LimTop) begin
      lim = LimTop;
    end else begin
      lim = max_q;
    end
  end

  // Line edit on the incoming byte
  always_comb begin
    fill_ext     = LenW'(fill_q);
    nfill        = fill_ext;
    delim_commit = '0;
    is_printable = 1'b0;
    priority if (s_axis_tdata == ChNone) begin
      nfill = fill_ext;
    end else if (s_axis_tdata == ChBs || s_axis_tdata == ChDel) begin
      // drop the newest byte; the stale entry is never read again
      if (fill_ext != '0) begin
        nfill = fill_ext - LenW'(1);
      end
    end else if (s_axis_tdata == ChSpace || s_axis_tdata == ChCr ||
                 s_axis_tdata == ChLf) begin
      delim_commit = fill_ext;
    end else begin
      // stored fill stays below the top of the buffer, so it always fits
      nfill        = fill_ext + LenW'(1);
      is_printable = 1'b1;
    end
    // length check runs after every byte, delimiter or not
    commit = (nfill >= lim) ? lim : delim_commit;
  end

  assign ram_we = in_xfer && is_printable;

  // Two-stage read pipeline: RAM data register, then output register
  assign b_load     = !b_vld_q || m_axis_tready;
  assign a_move     = a_vld_q && b_load;
  assign ram_re     = (state_q == StEmit) && (!a_vld_q || a_move);
  assign rd_idx_inc = rd_idx_q + LenW'(1);

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    max_d    = max_q;
    len_d    = len_q;
    rd_idx_d = rd_idx_q;
    a_vld_d  = a_vld_q;
    a_last_d = a_last_q;
    a_len_d  = a_len_q;
    b_vld_d  = b_vld_q;
    b_last_d = b_last_q;
    b_len_d  = b_len_q;
    b_byte_d = b_byte_q;

    if (cfg_valid_i && cfg_ready_o) begin
      max_d = cfg_data_i;
    end

    // accept a byte: append, erase, ignore or commit
    if (in_xfer) begin
      if (commit != '0) begin
        state_d  = StEmit;
        len_d    = commit;
        rd_idx_d = '0;
        fill_d   = '0;
      end else begin
        fill_d = nfill[FillW-1:0];
      end
    end

    // advance stage A into the output register
    if (b_load) begin
      b_vld_d  = a_vld_q;
      b_last_d = a_last_q;
      b_len_d  = a_len_q;
      b_byte_d = ram_rdata;
    end

    // issue the next read, or drain stage A
    if (ram_re) begin
      a_vld_d  = 1'b1;
      a_last_d = (rd_idx_inc == len_q);
      a_len_d  = len_q;
      rd_idx_d = rd_idx_inc;
      if (rd_idx_inc == len_q) begin
        state_d = StIdle;
      end
    end else if (a_move) begin
      a_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      max_q    <= MaxLenReset;
      len_q    <= '0;
      rd_idx_q <= '0;
      a_vld_q  <= 1'b0;
      a_last_q <= 1'b0;
      a_len_q  <= '0;
      b_vld_q  <= 1'b0;
      b_last_q <= 1'b0;
      b_len_q  <= '0;
      b_byte_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      max_q    <= max_d;
      len_q    <= len_d;
      rd_idx_q <= rd_idx_d;
      a_vld_q  <= a_vld_d;
      a_last_q <= a_last_d;
      a_len_q  <= a_len_d;
      b_vld_q  <= b_vld_d;
      b_last_q <= b_last_d;
      b_len_q  <= b_len_d;
      b_byte_q <= b_byte_d;
    end
  end

  cla_ram #(
    .Width(ByteW),
    .Depth(BufferDepth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[FillW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = b_vld_q;
  assign m_axis_tdata  = {2'b00, b_len_q, b_byte_q};
  assign m_axis_tlast  = b_last_q;

  // Stored fill stays below the top of the buffer between bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(fill_q) < LimTop)
    else $error("fill count reached the buffer limit");

  // Read-out never runs past the committed length, which is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> (rd_idx_q < len_q) && (len_q != '0))
    else $error("read index out of range during read-out");

  // Every delivered character belongs to a non-empty line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (b_len_q != '0))
    else $error("character emitted with zero line length");

  // A committing transfer starts read-out on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (commit != '0)) |=> (state_q == StEmit) && (rd_idx_q == '0))
    else $error("commit did not start read-out");

endmodule

// File: test/console_line_assembler_tb.sv
// Self-checking testbench for console_line_assembler: typed bytes in, committed
// line characters out, checked against an in-bench model of the line buffer.
// Depends on cla_pkg and the console_line_assembler RTL.
module console_line_assembler_tb;
  import cla_pkg::*;

  // One expected character of a committed line
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic [LenW-1:0]  len;
    logic             is_last;
  } line_char_t;

  // Directed script: a row either types a key or writes the maximum length
  typedef enum logic {RowKey, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [ByteW-1:0]  val;
    logic signed [7:0] n_chars;  // characters the key must release, -1: not typed in
  } script_row_t;

  localparam int NumRows = 32;

  localparam script_row_t Script [NumRows] = '{
    '{RowKey, ChBs,    8'sd0},   // erase on an empty line
    '{RowKey, ChSpace, 8'sd0},   // delimiter on an empty line
    '{RowKey, 8'h41,   8'sd0},
    '{RowKey, 8'h00,   8'sd0},
    '{RowKey, ChNone,  8'sd0},   // no character
    '{RowKey, 8'hFE,   8'sd0},
    '{RowKey, ChDel,   8'sd0},   // drops 8'hFE
    '{RowKey, ChCr,    8'sd2},
    '{RowKey, 8'h78,   8'sd0},
    '{RowKey, ChLf,    8'sd1},
    '{RowCfg, 8'd1,    -8'sd1},
    '{RowKey, 8'h5A,   8'sd1},   // one-character lines commit on their own
    '{RowKey, 8'h80,   8'sd1},
    '{RowCfg, 8'd0,    -8'sd1},  // zero acts as one
    '{RowKey, 8'h01,   8'sd1},
    '{RowCfg, 8'd5,    -8'sd1},
    '{RowKey, 8'h61,   8'sd0},
    '{RowKey, 8'h62,   8'sd0},
    '{RowKey, 8'h63,   8'sd0},
    '{RowKey, 8'h64,   8'sd0},
    '{RowCfg, 8'd2,    -8'sd1},  // lower the limit below the fill count
    '{RowKey, ChNone,  8'sd2},   // ignored byte still runs the length check
    '{RowKey, 8'h65,   8'sd0},
    '{RowKey, ChBs,    8'sd0},
    '{RowKey, ChLf,    8'sd0},
    '{RowCfg, 8'd5,    -8'sd1},
    '{RowKey, 8'h31,   8'sd0},
    '{RowKey, 8'h32,   8'sd0},
    '{RowKey, 8'h33,   8'sd0},
    '{RowCfg, 8'd2,    -8'sd1},
    '{RowKey, ChDel,   8'sd2},   // erase over a lowered limit commits
    '{RowCfg, 8'd63,   -8'sd1}
  };

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata = '0;   // [7:0] in_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;        // [7:0] out_byte, [13:8] line_length, [15:14] zero
  logic             m_axis_tlast;        // last_of_line

  // Line buffer model
  logic [ByteW-1:0] typed_chars [BufferDepthDefault];
  int               chars_held = 0;
  logic [LenW-1:0]  max_len_q = MaxLenReset;
  line_char_t       pending_chars [$];

  int         mismatches = 0;
  bit         calm = 1'b0;
  int         gap_pct = 20;
  int         stall_left = 0;
  line_char_t head_char;

  console_line_assembler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Apply one accepted key to the line model, queue the characters it
  // releases and return how many there are.
  function automatic int apply_key(input logic [ByteW-1:0] key);
    int lim;
    int commit;
    lim = (max_len_q == 0) ? 1 : int'(max_len_q);
    if (lim > BufferDepthDefault - 1) lim = BufferDepthDefault - 1;
    commit = 0;
    if (key == ChBs || key == ChDel) begin
      if (chars_held > 0) chars_held--;
    end else if (key == ChSpace || key == ChCr || key == ChLf) begin
      commit = chars_held;
    end else if (key != ChNone && chars_held < BufferDepthDefault) begin
      typed_chars[chars_held] = key;
      chars_held++;
    end
    // Length check runs after every key; bytes past the limit are dropped
    if (chars_held >= lim) commit = lim;
    for (int k = 0; k < commit; k++) begin
      pending_chars.push_back('{ch: typed_chars[k], len: LenW'(commit),
                                 is_last: (k == commit - 1)});
    end
    if (commit > 0) chars_held = 0;
    return commit;
  endfunction

  function automatic logic [ByteW-1:0] rand_char();
    logic [ByteW-1:0] c;
    do c = ByteW'($urandom_range(0, 255));
    while (c == ChBs || c == ChDel || c == ChSpace || c == ChCr || c == ChLf ||
           c == ChNone);
    return c;
  endfunction

  // Present one key, with an optional idle burst first, and hold it until the
  // transfer. The model is updated at the accepting edge.
  task automatic send_key(input logic [ByteW-1:0] key, output int n_chars);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    n_chars = apply_key(key);
  endtask

  // Drain the block, then write the maximum line length
  task automatic write_max_len(input logic [LenW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    // a key with no output may still be in flight
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Output stalls in bursts; none in the calm phase
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every character transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected character %h", m_axis_tdata[7:0]));
      end else begin
        head_char = pending_chars.pop_front();
        if (m_axis_tdata[7:0] !== head_char.ch)
          flag_mismatch($sformatf("out_byte exp %h got %h", head_char.ch,
                                  m_axis_tdata[7:0]));
        if (m_axis_tdata[13:8] !== head_char.len)
          flag_mismatch($sformatf("line_length exp %0d got %0d", head_char.len,
                                  m_axis_tdata[13:8]));
        if (m_axis_tlast !== head_char.is_last)
          flag_mismatch($sformatf("last_of_line exp %b got %b", head_char.is_last,
                                  m_axis_tlast));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("** console_line_assembler: FAILED **");
    $finish;
  end

  initial begin
    logic [LenW-1:0]  phase_max [8];
    logic [ByteW-1:0] key;
    int               n;
    int               budget;
    int               sent;
    int               eff;
    int               len;
    int               r;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    for (int i = 0; i < NumRows; i++) begin
      if (Script[i].kind == RowCfg) begin
        write_max_len(Script[i].val[LenW-1:0]);
      end else begin
        send_key(Script[i].val, n);
        if (Script[i].n_chars >= 0 && n != int'(Script[i].n_chars))
          flag_mismatch($sformatf("row %0d releases %0d characters, expected %0d",
                                  i, n, Script[i].n_chars));
      end
    end

    // Random part: mostly typed lines with edits, some raw noise
    phase_max = '{6'd63, 6'd0, 6'd1, 6'd2, LenW'($urandom_range(3, 62)), 6'd7,
                  6'd63, LenW'($urandom_range(1, 63))};
    for (int p = 0; p < 8; p++) begin
      calm    = (p == 7);
      gap_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      write_max_len(phase_max[p]);
      budget = (phase_max[p] >= 40) ? 45 : 35;
      sent = 0;
      while (sent < budget) begin
        if ($urandom_range(0, 9) < 7) begin
          eff = (phase_max[p] == 0) ? 1 : int'(phase_max[p]);
          // a third of the lines run into the length limit
          len = ($urandom_range(0, 2) == 0) ? eff + $urandom_range(0, 2)
                                            : $urandom_range(1, eff);
          for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) key = ChBs;
            else if (r == 1) key = ChDel;
            else if (r == 2) key = ChNone;
            else key = rand_char();
            send_key(key, n);
            if (key != ChNone) sent++;
          end
          case ($urandom_range(0, 2))
            0:       key = ChSpace;
            1:       key = ChCr;
            default: key = ChLf;
          endcase
          send_key(key, n);
          sent++;
        end else begin
          key = ByteW'($urandom_range(0, 255));
          send_key(key, n);
          if (key != ChNone) sent++;
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** console_line_assembler: PASSED **");
    end else begin
      $display("** console_line_assembler: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/cla_pkg.sv
hw/rtl/cla_ram.sv
hw/rtl/console_line_assembler.sv
test/console_line_assembler_tb.sv
